// ===== hw/rtl/cvf_pkg.sv =====
// Shared types and constants for the cut vertex finder.
// No dependencies; every other file of the block but cvf_ram imports this package.
package cvf_pkg;

  // Largest graph the adjacency store holds.
  localparam int MAX_NODES  = 64;
  // Vertex numbers and counts as they appear on the ports (0..127).
  localparam int NODE_W     = 7;
  // Index of a vertex bit within a row.
  localparam int IDX_W      = $clog2(MAX_NODES);
  // Stream payload widths, padded to whole bytes.
  localparam int S_DATA_W   = 16;
  localparam int M_DATA_W   = 8;
  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes on the configuration port.
  localparam logic [0:0] REG_NODE_COUNT = 1'b0;

  localparam logic [NODE_W-1:0] NODE_COUNT_RESET = NODE_W'(MAX_NODES);

  typedef logic [MAX_NODES-1:0] vmask_t;

  // Result of the shared lowest-set-bit search.
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } ffs_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A,
    ST_WR_A,
    ST_RD_B,
    ST_WR_B,
    ST_START,
    ST_SEEK,
    ST_POP,
    ST_EXP,
    ST_JUDGE,
    ST_DECIDE,
    ST_PUSH,
    ST_FINAL
  } state_e;

endpackage

// ===== hw/rtl/cvf_ram.sv =====
// Generic single-port RAM with a registered read.
// Stand-alone; used for the adjacency rows of the cut vertex finder.
module cvf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read-first port: the read word is the old content on a write cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/cvf_ffs.sv =====
// Lowest-set-bit search over one vertex mask.
// Depends on cvf_pkg; shared by the component seek and the flood frontier.
module cvf_ffs (
  input  cvf_pkg::vmask_t   word_i,
  output cvf_pkg::ffs_res_t res_o
);
  import cvf_pkg::*;

  // Scan from the top so the lowest set bit wins.
  always_comb begin
    res_o.hit = |word_i;
    res_o.idx = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (word_i[i]) begin
        res_o.idx = IDX_W'(i);
      end
    end
  end

endmodule

// ===== hw/rtl/cvf_apb.sv =====
// APB-style register file holding the node count.
// Depends on cvf_pkg for the address map and register widths.
module cvf_apb (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [cvf_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [cvf_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [cvf_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready,
  output logic [cvf_pkg::NODE_W-1:0]         node_count_o
);
  import cvf_pkg::*;

  logic [NODE_W-1:0] node_count_q;
  logic [0:0]        reg_idx;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready && (reg_idx == REG_NODE_COUNT);

  // Node count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RESET;
    end else if (wr_en) begin
      node_count_q <= pwdata[NODE_W-1:0];
    end
  end

  // Read back; unmapped addresses read as zero.
  always_comb begin
    prdata = '0;
    if (reg_idx == REG_NODE_COUNT) begin
      prdata = CFG_DATA_W'(node_count_q);
    end
  end

  assign node_count_o = node_count_q;

endmodule

// ===== hw/rtl/cut_vertex_finder.sv =====
// Top level of the cut vertex finder: sequencer, flood datapath and ports.
// Depends on cvf_pkg, cvf_ram, cvf_ffs and cvf_apb.
//
// Edges of one undirected graph stream in one word at a time and are set into
// a 64-row adjacency RAM. A word with a stored edge is accepted, then both rows
// are read and rewritten in turn (RD_A, WR_A, RD_B, WR_B); any other word is only
// accepted. The word with tlast high starts the search: the connected components
// over vertices 1..node_count (at most 64) are counted once whole and once per
// removed vertex, each count being a flood driven by one shared lowest-set-bit
// unit and one RAM row read per reached vertex. The input is stalled while an edge
// is stored and from the tlast word until the closing word is loaded for output.
// Cut vertices leave in increasing order with tuser (found) high and tlast on the
// final one; a graph without any yields one word with tuser low and tlast high.
// Row valid flops clear the whole store after each graph and at reset, so no
// clearing pass is needed.
module cut_vertex_finder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Edge stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: node_a [6:0], node_b [13:7], zero [15:14].
  input  logic [cvf_pkg::S_DATA_W-1:0]   s_axis_tdata,
  // tuser: edge_valid [0].
  input  logic                           s_axis_tuser,
  // tlast: end_of_graph.
  input  logic                           s_axis_tlast,
  // Result stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: cut_vertex [6:0], zero [7].
  output logic [cvf_pkg::M_DATA_W-1:0]   m_axis_tdata,
  // tuser: found [0].
  output logic                           m_axis_tuser,
  // tlast: last.
  output logic                           m_axis_tlast,
  // Configuration port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cvf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [cvf_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [cvf_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import cvf_pkg::*;

  state_e state_q, state_d;

  logic [NODE_W-1:0] node_count;
  logic [NODE_W-1:0] eff_n;
  vmask_t            range_mask;

  logic [NODE_W-1:0] a_q, a_d, b_q, b_d;
  logic [IDX_W-1:0]  a_idx, b_idx;
  logic              edge_ok;
  // End-of-graph flag of the word whose edge is being stored.
  logic              s_axis_tlast_q;

  vmask_t            row_valid_q, row_valid_d;
  logic              rd_valid_q;
  vmask_t            allowed_q, allowed_d;
  vmask_t            visited_q, visited_d;
  vmask_t            frontier_q, frontier_d;
  logic [NODE_W-1:0] count_q, count_d;
  logic [NODE_W-1:0] base_q, base_d;
  logic [NODE_W-1:0] trial_q, trial_d;
  logic [NODE_W-1:0] rem_q, rem_d;
  logic [NODE_W-1:0] pend_q, pend_d;
  logic              have_q, have_d;

  logic              out_valid_q;
  logic [NODE_W-1:0] out_vertex_q, out_vertex_d;
  logic              out_found_q, out_found_d;
  logic              out_last_q, out_last_d;
  logic              out_load, out_free;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_addr;
  vmask_t            ram_wdata, ram_rdata, row_word;

  vmask_t            ffs_word;
  ffs_res_t          ffs_res;

  cvf_apb u_apb (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .node_count_o (node_count)
  );

  cvf_ram #(
    .WIDTH (MAX_NODES),
    .DEPTH (MAX_NODES)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  cvf_ffs u_ffs (
    .word_i (ffs_word),
    .res_o  (ffs_res)
  );

  // Effective vertex count and the mask of vertices that take part.
  always_comb begin
    eff_n = (node_count > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES) : node_count;
    for (int j = 0; j < MAX_NODES; j++) begin
      range_mask[j] = (NODE_W'(j) < eff_n);
    end
  end

  // Incoming edge endpoints and their row indexes.
  assign a_d     = s_axis_tdata[NODE_W-1:0];
  assign b_d     = s_axis_tdata[2*NODE_W-1:NODE_W];
  assign edge_ok = s_axis_tuser && (a_d >= NODE_W'(1)) && (a_d <= eff_n) &&
                   (b_d >= NODE_W'(1)) && (b_d <= eff_n);
  assign a_idx   = IDX_W'(a_q - NODE_W'(1));
  assign b_idx   = IDX_W'(b_q - NODE_W'(1));

  // A row never written since the last clear reads as zero.
  assign row_word = rd_valid_q ? ram_rdata : '0;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign ffs_word      = (state_q == ST_SEEK) ? (allowed_q & ~visited_q) : frontier_q;

  // Sequencer: edge load, component counts and result hand-off.
  always_comb begin
    logic advance;
    vmask_t nb;
    state_d      = state_q;
    row_valid_d  = row_valid_q;
    allowed_d    = allowed_q;
    visited_d    = visited_q;
    frontier_d   = frontier_q;
    count_d      = count_q;
    base_d       = base_q;
    trial_d      = trial_q;
    rem_d        = rem_q;
    pend_d       = pend_q;
    have_d       = have_q;
    out_load     = 1'b0;
    out_vertex_d = out_vertex_q;
    out_found_d  = out_found_q;
    out_last_d   = out_last_q;
    ram_we       = 1'b0;
    ram_addr     = '0;
    ram_wdata    = '0;
    advance      = 1'b0;
    nb           = row_word & allowed_q & ~visited_q;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (edge_ok) begin
            state_d = ST_RD_A;
          end else if (s_axis_tlast) begin
            rem_d   = '0;
            state_d = ST_START;
          end
        end
      end
      ST_RD_A: begin
        ram_addr = a_idx;
        state_d  = ST_WR_A;
      end
      ST_WR_A: begin
        ram_addr           = a_idx;
        ram_we             = 1'b1;
        ram_wdata          = row_word | (vmask_t'(1) << b_idx);
        row_valid_d[a_idx] = 1'b1;
        state_d            = ST_RD_B;
      end
      ST_RD_B: begin
        ram_addr = b_idx;
        state_d  = ST_WR_B;
      end
      ST_WR_B: begin
        ram_addr           = b_idx;
        ram_we             = 1'b1;
        ram_wdata          = row_word | (vmask_t'(1) << a_idx);
        row_valid_d[b_idx] = 1'b1;
        if (s_axis_tlast_q) begin
          rem_d   = '0;
          state_d = ST_START;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_START: begin
        // Vertex zero means nothing is removed.
        allowed_d = range_mask;
        if (rem_q >= NODE_W'(1) && rem_q <= eff_n) begin
          allowed_d[IDX_W'(rem_q - NODE_W'(1))] = 1'b0;
        end
        visited_d = '0;
        count_d   = '0;
        state_d   = ST_SEEK;
      end
      ST_SEEK: begin
        // Open a new component at the lowest unvisited vertex.
        if (ffs_res.hit) begin
          count_d                 = count_q + NODE_W'(1);
          visited_d[ffs_res.idx]  = 1'b1;
          frontier_d              = vmask_t'(1) << ffs_res.idx;
          state_d                 = ST_POP;
        end else begin
          state_d = ST_JUDGE;
        end
      end
      ST_POP: begin
        if (ffs_res.hit) begin
          frontier_d[ffs_res.idx] = 1'b0;
          ram_addr                = ffs_res.idx;
          state_d                 = ST_EXP;
        end else begin
          state_d = ST_SEEK;
        end
      end
      ST_EXP: begin
        visited_d  = visited_q | nb;
        frontier_d = frontier_q | nb;
        state_d    = ST_POP;
      end
      ST_JUDGE: begin
        if (rem_q == '0) begin
          base_d  = count_q;
          advance = 1'b1;
        end else begin
          trial_d = count_q;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (trial_q > base_q) begin
          if (have_q) begin
            state_d = ST_PUSH;
          end else begin
            pend_d  = rem_q;
            have_d  = 1'b1;
            advance = 1'b1;
          end
        end else begin
          advance = 1'b1;
        end
      end
      ST_PUSH: begin
        // The held vertex is known not to be the final one.
        if (out_free) begin
          out_load     = 1'b1;
          out_vertex_d = pend_q;
          out_found_d  = 1'b1;
          out_last_d   = 1'b0;
          pend_d       = rem_q;
          advance      = 1'b1;
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_vertex_d = have_q ? pend_q : '0;
          out_found_d  = have_q;
          out_last_d   = 1'b1;
          have_d       = 1'b0;
          row_valid_d  = '0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Move on to the next removed vertex or to the closing word.
    if (advance) begin
      if (rem_q < eff_n) begin
        rem_d   = rem_q + NODE_W'(1);
        state_d = ST_START;
      end else begin
        state_d = ST_FINAL;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_valid_q <= '0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
      base_q      <= '0;
      trial_q     <= '0;
      rem_q       <= '0;
      visited_q   <= '0;
    end else begin
      state_q     <= state_d;
      row_valid_q <= row_valid_d;
      have_q      <= have_d;
      base_q      <= base_d;
      trial_q     <= trial_d;
      rem_q       <= rem_d;
      visited_q   <= visited_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      a_q            <= a_d;
      b_q            <= b_d;
      s_axis_tlast_q <= s_axis_tlast;
    end
    rd_valid_q   <= row_valid_q[ram_addr];
    allowed_q    <= allowed_d;
    frontier_q   <= frontier_d;
    count_q      <= count_d;
    pend_q       <= pend_d;
    out_vertex_q <= out_vertex_d;
    out_found_q  <= out_found_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_DATA_W'(out_vertex_q);
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tlast  = out_last_q;

endmodule
